@@ rtl/lome_pkg.sv @@
package lome_pkg;

  localparam int BOOK_SLOTS_DEF = 32;

  localparam int ID_W   = 32;
  localparam int PRICE_W = 16;
  localparam int QTY_W  = 24;
  localparam int TIME_W = 48;
  localparam int ARR_W  = 32;

  // one resting entry: id, price, remaining, arrival
  localparam int ENTRY_W = ID_W + PRICE_W + QTY_W + ARR_W;

  // input tdata: order_id, limit_price, quantity, order_time
  localparam int IN_W = 120;
  // input tuser: side, order_kind
  localparam int IN_USER_W = 2;
  // output tdata: taker_id, maker_id, fill_price, fill_qty, fill_time, end_status
  localparam int OUT_W = 160;

  typedef enum logic [1:0] {
    ST_FILLED  = 2'd0,
    ST_RESTED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_REJECT  = 2'd3
  } end_status_t;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   remaining;
    logic [ARR_W-1:0]   arrival;
  } entry_t;

endpackage

@@ rtl/lome_ram.sv @@
module lome_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/limit_order_matching_engine.sv @@
// each result costs one scan of the book, one decision step (S_DEC) and its transfer;
//   the scan sweeps the entry ram read port one slot a cycle in search of the best maker
// one order is handled at a time; the next is accepted once its end item is taken
// reset (rst, synchronous) clears the valid flags, arrival counter and control state only
module limit_order_matching_engine #(
  parameter int BOOK_SLOTS = lome_pkg::BOOK_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // order_id, limit_price, quantity, order_time
  input  logic [lome_pkg::IN_W-1:0]      s_tdata,
  // side, order_kind
  input  logic [lome_pkg::IN_USER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // taker_id, maker_id, fill_price, fill_qty, fill_time, end_status
  output logic [lome_pkg::OUT_W-1:0]     m_tdata,
  // item_kind
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import lome_pkg::*;

  localparam int AW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam int RD = (BOOK_SLOTS > 1) ? BOOK_SLOTS : 2;
  localparam int CW = $clog2(BOOK_SLOTS + 1) + 1;
  localparam logic [CW-1:0] LAST_SLOT = CW'(BOOK_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DEC   = 5'b00100,
    S_OUT   = 5'b01000,
    S_END   = 5'b10000
  } state_t;

  state_t state;

  // taker registers
  logic              t_sell, t_mkt;
  logic [ID_W-1:0]   t_id;
  logic [PRICE_W-1:0] t_limit;
  logic [QTY_W-1:0]  t_rem;
  logic [TIME_W-1:0] t_time;

  logic [BOOK_SLOTS-1:0] bid_valid, ask_valid;
  logic [ARR_W-1:0] arr_cnt;

  // scan state
  logic [CW-1:0] scan_idx;     // address issued
  logic          rd_pend;      // read data valid this cycle
  logic [AW-1:0] rd_slot;
  logic          best_ok;
  logic [AW-1:0] best_slot;
  entry_t        best;
  logic [ARR_W-1:0] best_age;

  // ram ports
  logic          bid_we, ask_we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, bid_rd, ask_rd, rd_e;

  lome_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_bid (
    .clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(bid_rd)
  );
  lome_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ask (
    .clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(ask_rd)
  );

  assign raddr = scan_idx[AW-1:0];
  assign rd_e  = t_sell ? bid_rd : ask_rd;

  logic [BOOK_SLOTS-1:0] opp_valid, own_valid;
  assign opp_valid = t_sell ? bid_valid : ask_valid;
  assign own_valid = t_sell ? ask_valid : bid_valid;

  // candidate compare for the entry just read
  logic [ARR_W-1:0] rd_age;
  logic rd_live, rd_better;
  assign rd_age  = arr_cnt - rd_e.arrival;
  assign rd_live = rd_pend && opp_valid[rd_slot];
  always_comb begin
    if (!best_ok) rd_better = 1'b1;
    else if (rd_e.price == best.price) rd_better = rd_age > best_age;
    else rd_better = t_sell ? (rd_e.price > best.price) : (rd_e.price < best.price);
  end

  // lowest free slot on own side
  logic          free_ok;
  logic [AW-1:0] free_slot;
  always_comb begin
    free_ok = 1'b0;
    free_slot = '0;
    for (int i = BOOK_SLOTS - 1; i >= 0; i--) begin
      if (!own_valid[i]) begin
        free_ok = 1'b1;
        free_slot = AW'(i);
      end
    end
  end

  logic crosses;
  assign crosses = t_mkt || (t_sell ? (t_limit <= best.price) : (t_limit >= best.price));

  logic [QTY_W-1:0] fq;
  assign fq = (t_rem < best.remaining) ? t_rem : best.remaining;

  // output register
  logic        o_kind;
  logic [ID_W-1:0] o_maker;
  logic [PRICE_W-1:0] o_price;
  logic [QTY_W-1:0] o_qty;
  end_status_t o_status;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT) || (state == S_END);
  assign m_tlast  = (state == S_END);
  assign m_tuser  = o_kind;
  assign m_tdata  = {6'd0, o_status, t_time, o_qty, o_price, o_maker, t_id};

  // write-back of the matched maker or the new resting entry
  always_comb begin
    bid_we = 1'b0;
    ask_we = 1'b0;
    waddr  = best_slot;
    wdata  = best;
    wdata.remaining = best.remaining - fq;
    if (state == S_DEC && t_rem != '0 && best_ok && crosses) begin
      bid_we = t_sell;
      ask_we = !t_sell;
    end else if (state == S_DEC && t_rem != '0 && !t_mkt && free_ok) begin
      waddr = free_slot;
      wdata = '{id: t_id, price: t_limit, remaining: t_rem, arrival: arr_cnt};
      bid_we = !t_sell;
      ask_we = t_sell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bid_valid <= '0;
      ask_valid <= '0;
      arr_cnt <= '0;
      rd_pend <= 1'b0;
      best_ok <= 1'b0;
      scan_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            {t_time, t_rem, t_limit, t_id} <= s_tdata;
            {t_mkt, t_sell} <= s_tuser;
            scan_idx <= '0;
            rd_pend <= 1'b0;
            best_ok <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // sweep read addresses, fold each returned entry into best
          rd_pend <= (scan_idx <= LAST_SLOT);
          rd_slot <= scan_idx[AW-1:0];
          if (scan_idx <= LAST_SLOT) scan_idx <= scan_idx + 1'b1;
          if (rd_live && rd_better) begin
            best_ok <= 1'b1;
            best <= rd_e;
            best_age <= rd_age;
            best_slot <= rd_slot;
          end
          if (scan_idx > LAST_SLOT && !rd_pend) state <= S_DEC;
        end
        S_DEC: begin
          o_maker <= '0;
          o_price <= '0;
          o_qty <= '0;
          if (t_rem != '0 && best_ok && crosses) begin
            o_kind <= KIND_FILL;
            o_maker <= best.id;
            o_price <= best.price;
            o_qty <= fq;
            o_status <= ST_FILLED;
            t_rem <= t_rem - fq;
            if (best.remaining == fq) begin
              if (t_sell) bid_valid[best_slot] <= 1'b0;
              else ask_valid[best_slot] <= 1'b0;
            end
            state <= S_OUT;
          end else begin
            o_kind <= KIND_END;
            if (t_rem == '0) o_status <= ST_FILLED;
            else if (t_mkt) o_status <= ST_DROPPED;
            else if (!free_ok) o_status <= ST_REJECT;
            else begin
              o_status <= ST_RESTED;
              if (t_sell) ask_valid[free_slot] <= 1'b1;
              else bid_valid[free_slot] <= 1'b1;
              arr_cnt <= arr_cnt + 1'b1;
            end
            state <= S_END;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            scan_idx <= '0;
            rd_pend <= 1'b0;
            best_ok <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_END: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/lome_checker.sv @@
module lome_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [lome_pkg::IN_W-1:0]      s_tdata,
  input logic [lome_pkg::IN_USER_W-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lome_pkg::OUT_W-1:0]     m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import lome_pkg::*;

  // last marks exactly the end item
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser)) else $error("tlast does not match item kind");

  // fill items carry a nonzero quantity and a zero status
  a_fill_qty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[103:80] != '0 && m_tdata[153:152] == ST_FILLED))
    else $error("bad fill item");

  // no new order taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input accepted during output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed under stall");

  // a waiting input holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tuser)))
    else $error("input changed while waiting");
endmodule

bind limit_order_matching_engine lome_checker u_chk (.*);

@@ sim/limit_order_matching_engine_tb.sv @@
`timescale 1ns / 100ps

module limit_order_matching_engine_tb;
  import lome_pkg::*;

  localparam int SLOTS = BOOK_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [47:0] order_time;
    logic [23:0] quantity;
    logic [15:0] limit_price;
    logic [31:0] order_id;
    logic        order_kind;
    logic        side;
  } order_t;

  typedef struct packed {
    logic [1:0]  end_status;
    logic [47:0] fill_time;
    logic [23:0] fill_qty;
    logic [15:0] fill_price;
    logic [31:0] maker_id;
    logic [31:0] taker_id;
  } trade_t;

  typedef struct {
    trade_t t;
    logic   kind;
    logic   last;
  } trade_rec_t;

  // book mirror and expected trade queue
  class match_scoreboard;
    bit          valid [2][SLOTS];
    bit [31:0]   id [2][SLOTS];
    bit [15:0]   price [2][SLOTS];
    bit [23:0]   remain [2][SLOTS];
    bit [31:0]   arrival [2][SLOTS];
    bit [31:0]   arr_cnt;
    trade_rec_t  pending [$];
    int          errors;

    function int best_maker(int s, bit want_low);
      int b;
      bit [31:0] bage, age;
      bit better;
      b = -1;
      bage = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!valid[s][i]) continue;
        age = arr_cnt - arrival[s][i];
        if (b < 0) begin
          b = i;
          bage = age;
          continue;
        end
        better = want_low ? (price[s][i] < price[s][b]) : (price[s][i] > price[s][b]);
        if (better || (price[s][i] == price[s][b] && age > bage)) begin
          b = i;
          bage = age;
        end
      end
      return b;
    endfunction

    function void note_order(order_t o);
      int opp, own, m, f;
      bit [23:0] rem, q;
      trade_rec_t r;
      end_status_t st;
      opp = o.side ? 0 : 1;
      own = o.side ? 1 : 0;
      rem = o.quantity;
      while (rem > 0) begin
        m = best_maker(opp, !o.side);
        if (m < 0) break;
        if (!o.order_kind && (o.side ? (o.limit_price > price[opp][m])
                                     : (o.limit_price < price[opp][m]))) break;
        q = rem < remain[opp][m] ? rem : remain[opp][m];
        r.t = '{end_status: ST_FILLED, fill_time: o.order_time, fill_qty: q,
                fill_price: price[opp][m], maker_id: id[opp][m],
                taker_id: o.order_id};
        r.kind = KIND_FILL;
        r.last = 1'b0;
        pending.push_back(r);
        rem -= q;
        remain[opp][m] -= q;
        if (remain[opp][m] == 0) valid[opp][m] = 1'b0;
      end
      if (rem == 0) st = ST_FILLED;
      else if (o.order_kind) st = ST_DROPPED;
      else begin
        f = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!valid[own][i] && f < 0) f = i;
        if (f < 0) st = ST_REJECT;
        else begin
          valid[own][f] = 1'b1;
          id[own][f] = o.order_id;
          price[own][f] = o.limit_price;
          remain[own][f] = rem;
          arrival[own][f] = arr_cnt;
          arr_cnt++;
          st = ST_RESTED;
        end
      end
      r.t = '{end_status: st, fill_time: o.order_time, fill_qty: '0, fill_price: '0,
              maker_id: '0, taker_id: o.order_id};
      r.kind = KIND_END;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void check_trade(trade_t a, logic akind, logic alast);
      trade_rec_t e;
      if (pending.size() == 0) begin
        $error("unexpected transfer %h", a);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (akind !== e.kind) begin
        $error("item_kind exp %0d got %0d", e.kind, akind); errors++; end
      if (a.taker_id !== e.t.taker_id) begin
        $error("taker_id exp %0h got %0h", e.t.taker_id, a.taker_id); errors++; end
      if (a.maker_id !== e.t.maker_id) begin
        $error("maker_id exp %0h got %0h", e.t.maker_id, a.maker_id); errors++; end
      if (a.fill_price !== e.t.fill_price) begin
        $error("fill_price exp %0d got %0d", e.t.fill_price, a.fill_price); errors++; end
      if (a.fill_qty !== e.t.fill_qty) begin
        $error("fill_qty exp %0d got %0d", e.t.fill_qty, a.fill_qty); errors++; end
      if (a.fill_time !== e.t.fill_time) begin
        $error("fill_time exp %0h got %0h", e.t.fill_time, a.fill_time); errors++; end
      if (a.end_status !== e.t.end_status) begin
        $error("end_status exp %0d got %0d", e.t.end_status, a.end_status); errors++; end
      if (alast !== e.last) begin
        $error("last exp %0d got %0d", e.last, alast); errors++; end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  match_scoreboard book = new();
  int cycles = 0;
  bit hold_rx = 1'b0;

  limit_order_matching_engine u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: check transfers, random stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        book.check_trade(trade_t'(m_tdata[153:0]), m_tuser, m_tlast);
    end
  end

  initial begin : rx_stall
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
      end
      g = (cycles % 20000 < 5000) ? 0 : gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_order(order_t o);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {o.order_time, o.quantity, o.limit_price, o.order_id};
    s_tuser <= {o.order_kind, o.side};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_order(o);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  function automatic order_t mk(bit sd, bit mkt, bit [15:0] p, bit [23:0] q);
    order_t o;
    o.side = sd;
    o.order_kind = mkt;
    o.order_id = $urandom;
    o.limit_price = p;
    o.quantity = q;
    o.order_time = 48'({$urandom, $urandom});
    return o;
  endfunction

  // near-market price band so orders cross often
  function automatic order_t rnd_order();
    order_t o;
    int r;
    r = $urandom_range(0, 99);
    o = mk(1'($urandom), ($urandom_range(0, 9) == 0),
           16'(1000 + $urandom_range(0, 20) - 10), 24'($urandom_range(1, 50)));
    if (r < 5) o.limit_price = 16'($urandom);
    if (r >= 5 && r < 8) o.quantity = 24'($urandom);
    if (r == 8) o.quantity = 0;
    return o;
  endfunction

  initial begin : stim
    order_t o;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty book, extremes, zero qty, market on empty side
    send_order(mk(1'b0, 1'b1, 16'd5, 24'd10));
    send_order(mk(1'b1, 1'b0, 16'd0, 24'd0));
    o = mk(1'b0, 1'b0, 16'hFFFF, 24'hFFFFFF);
    o.order_id = '1;
    o.order_time = '1;
    send_order(o);
    o = mk(1'b1, 1'b0, 16'h0000, 24'd1);
    o.order_id = '0;
    o.order_time = '0;
    send_order(o);
    // same-price asks, time priority, then a buy sweeping them
    send_order(mk(1'b1, 1'b0, 16'd100, 24'd5));
    send_order(mk(1'b1, 1'b0, 16'd100, 24'd7));
    send_order(mk(1'b1, 1'b0, 16'd90, 24'd3));
    send_order(mk(1'b0, 1'b0, 16'd95, 24'd20));
    send_order(mk(1'b0, 1'b0, 16'd100, 24'd8));
    send_order(mk(1'b0, 1'b1, 16'd0, 24'd100));
    send_order(mk(1'b1, 1'b1, 16'd0, 24'd5));
    drain();

    // fill bid side to force book-full rejects
    for (int i = 0; i < SLOTS + 3; i++)
      send_order(mk(1'b0, 1'b0, 16'(10 + i % 4), 24'd2));
    // a sell market order that sweeps many makers
    send_order(mk(1'b1, 1'b1, 16'd0, 24'd200));

    // long receiver hold while sender keeps offering
    hold_rx = 1'b1;
    for (int i = 0; i < 10; i++) send_order(rnd_order());
    drain();

    for (int i = 0; i < 330; i++) begin
      send_order(rnd_order());
      if (i % 100 == 50) drain();
    end
    drain();
    repeat (400) @(posedge clk);

    if (book.errors == 0 && book.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
